// ===== design/lttb_pkg.sv =====
// Shared types and constants of the largest-triangle-three-buckets downsampler.
// Used by lttb_mac and lttb_downsampler; depends on nothing else.
package lttb_pkg;

  localparam int SAMPLE_WIDTH    = 32;
  localparam int MAX_SAMPLES_DEF = 65536;
  localparam int CNT_W           = 17;
  localparam int IDX_W           = 16;
  localparam int CFG_W           = 17;
  localparam logic [15:0] TARGET_DEFAULT = 16'd2000;

  // Configuration register indexes.
  localparam logic CFG_SAMPLE_COUNT  = 1'b0;
  localparam logic CFG_TARGET_POINTS = 1'b1;

  // Opcodes of the input channel.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // Multiply-accumulate unit widths.
  localparam int MAC_A_W = 36;
  localparam int MAC_B_W = 18;
  localparam int MAC_P_W = MAC_A_W + MAC_B_W;
  localparam int ACC_W   = 72;

  typedef struct packed {
    logic                           opcode;
    logic signed [SAMPLE_WIDTH-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]               point_index;
    logic signed [SAMPLE_WIDTH-1:0] point_value;
    logic                           last_point;
  } out_item_t;

  typedef enum logic [1:0] {
    MAC_SH0,
    MAC_SH17,
    MAC_SH34
  } mac_sh_t;

  typedef struct packed {
    logic    issue;
    logic    clr;
    mac_sh_t sh;
  } mac_ctl_t;

endpackage

// ===== design/lttb_mac.sv =====
// Shared signed multiply-accumulate unit: one 36x18 product per cycle,
// registered, then added to a 72-bit accumulator at a selectable shift.
// Depends on lttb_pkg.
module lttb_mac import lttb_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mac_ctl_t                  ctl,
  input  logic signed [MAC_A_W-1:0] a,
  input  logic signed [MAC_B_W-1:0] b,
  output logic signed [ACC_W-1:0]   acc
);

  mac_ctl_t                  ctl_r;
  logic signed [MAC_P_W-1:0] prod_r;
  logic signed [MAC_P_W-1:0] prod_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   addend;

  assign prod_nxt = a * b;
  assign prod_ext = ACC_W'(prod_r);

  always_comb begin
    case (ctl_r.sh)
      MAC_SH0:  addend = prod_ext;
      MAC_SH17: addend = prod_ext <<< 17;
      MAC_SH34: addend = prod_ext <<< 34;
      default:  addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl_r.issue) begin
      acc_r <= (ctl_r.clr ? ACC_W'(0) : acc_r) + addend;
    end
  end

  assign acc = acc_r;

endmodule

// ===== design/lttb_downsampler.sv =====
// Largest-triangle-three-buckets downsampler: samples are loaded one per
// transaction into an on-chip store, then points are fetched one per
// transaction. A pass-through fetch, and the first and last fetch, read
// one stored sample and emit it; the first fetch of a downsampled path
// also runs the bucket-width division first. A middle fetch sums the next
// bucket and then scores each candidate of the current bucket: the sample
// store has a single read port and is read once per sample, and each
// candidate's area needs four passes through the shared multiply-accumulate
// unit. Depends on lttb_pkg and lttb_mac.
module lttb_downsampler import lttb_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_SAMPLES);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DIV    = 5'd1;
  localparam logic [4:0] S_INIT   = 5'd2;
  localparam logic [4:0] S_BOUND  = 5'd3;
  localparam logic [4:0] S_SUM_RD = 5'd4;
  localparam logic [4:0] S_SUM_AC = 5'd5;
  localparam logic [4:0] S_ANC_RD = 5'd6;
  localparam logic [4:0] S_ANC_W  = 5'd7;
  localparam logic [4:0] S_PA0    = 5'd8;
  localparam logic [4:0] S_PA1    = 5'd9;
  localparam logic [4:0] S_PA2    = 5'd10;
  localparam logic [4:0] S_PB1    = 5'd11;
  localparam logic [4:0] S_PB2    = 5'd12;
  localparam logic [4:0] S_AR_RD  = 5'd13;
  localparam logic [4:0] S_AR_D   = 5'd14;
  localparam logic [4:0] S_M0     = 5'd15;
  localparam logic [4:0] S_M1     = 5'd16;
  localparam logic [4:0] S_M2     = 5'd17;
  localparam logic [4:0] S_M3     = 5'd18;
  localparam logic [4:0] S_M4     = 5'd19;
  localparam logic [4:0] S_M5     = 5'd20;
  localparam logic [4:0] S_READ   = 5'd21;
  localparam logic [4:0] S_EMIT   = 5'd22;

  logic [4:0]       state_r;
  logic [CNT_W-1:0] sample_count_r;
  logic [15:0]      target_r;
  logic [CNT_W-1:0] load_count_r;
  logic [IDX_W-1:0] emit_count_r;
  logic [IDX_W-1:0] anchor_r;
  logic [IDX_W-1:0] idx_r;
  logic             last_r;
  logic             mid_r;

  logic                           out_valid_r;
  out_item_t                      out_data_r;
  logic [SAMPLE_WIDTH-1:0]        mem [MAX_SAMPLES];
  logic signed [SAMPLE_WIDTH-1:0] rd_q;
  logic [CNT_W-1:0]               raddr;

  // Divider and bucket bound tracking.
  logic [16:0] div_rem_r;
  logic [15:0] div_quo_r;
  logic [3:0]  div_cnt_r;
  logic [17:0] q0_r, q1_r, q2_r;
  logic [15:0] r2_r;

  // Bucket walk.
  logic [CNT_W-1:0] start_r, end_r, ne_r, c_r, j_r, best_j_r;
  logic [32:0]               sx_r;
  logic signed [49:0]        sy_r;
  logic signed [31:0]        ay_r;
  logic signed [35:0]        pa_r;
  logic signed [49:0]        pb_r;
  logic signed [32:0]        dy_r;
  logic signed [17:0]        ndx_r;
  logic [ACC_W-1:0]          best_r;
  logic                      have_r;

  logic [CNT_W-1:0] n_eff, m_eff;
  logic [15:0]      t_eff, dvsr, dvd;
  logic             down, is_last, loaded, fetch_ok;

  mac_ctl_t                  mac_ctl;
  logic signed [MAC_A_W-1:0] mac_a;
  logic signed [MAC_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   acc;

  assign n_eff  = (32'(sample_count_r) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES)
                                                           : sample_count_r;
  assign t_eff  = (target_r < 16'd3) ? 16'd3 : target_r;
  assign down   = n_eff > {1'b0, t_eff};
  assign m_eff  = down ? {1'b0, t_eff} : n_eff;
  assign is_last = ({1'b0, emit_count_r} == m_eff - 1'b1);
  assign loaded = (n_eff != '0) && (load_count_r == n_eff);
  assign fetch_ok = loaded && ({1'b0, emit_count_r} < m_eff);
  assign dvsr   = t_eff - 16'd2;
  assign dvd    = 16'(n_eff - 17'd2);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Restoring division step, one quotient bit per cycle.
  logic [16:0] rem_sh;
  logic        div_ge;
  assign rem_sh = {div_rem_r[15:0], div_quo_r[15]};
  assign div_ge = rem_sh >= {1'b0, dvsr};

  // Next bucket bound: add the quotient and remainder of d/b once more.
  logic [16:0] adv_s_init, adv_s;
  logic        adv_ge_init, adv_ge;
  assign adv_s_init  = {1'b0, div_rem_r[15:0]} + {1'b0, div_rem_r[15:0]};
  assign adv_ge_init = adv_s_init >= {1'b0, dvsr};
  assign adv_s       = {1'b0, r2_r} + {1'b0, div_rem_r[15:0]};
  assign adv_ge      = adv_s >= {1'b0, dvsr};

  // Clamped bounds of the current and next bucket.
  logic [17:0] start18, endr, endc, endf, ner, nec, nef, n18, nm1;
  always_comb begin
    n18     = {1'b0, n_eff};
    nm1     = n18 - 18'd1;
    start18 = q0_r + 18'd1;
    endr    = q1_r + 18'd1;
    endc    = (endr > nm1) ? nm1 : endr;
    endf    = (endc <= start18) ? start18 + 18'd1 : endc;
    ner     = q2_r + 18'd1;
    nec     = (ner > n18) ? n18 : ner;
    nef     = (nec <= endc) ? endc + 18'd1 : nec;
  end

  logic [ACC_W-1:0] area;
  logic             take;
  assign area = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign take = !have_r || (area > best_r);

  always_comb begin
    case (state_r)
      S_SUM_RD, S_AR_RD: raddr = j_r;
      S_ANC_RD:          raddr = {1'b0, anchor_r};
      default:           raddr = {1'b0, idx_r};
    endcase
  end

  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    case (state_r)
      S_PA0: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b1, sh: MAC_SH0};
        mac_a   = MAC_A_W'(anchor_r);
        mac_b   = MAC_B_W'(c_r);
      end
      S_PA2: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b1, sh: MAC_SH0};
        mac_a   = MAC_A_W'(ay_r);
        mac_b   = MAC_B_W'(c_r);
      end
      S_M0: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b1, sh: MAC_SH0};
        mac_a   = pa_r;
        mac_b   = {1'b0, dy_r[16:0]};
      end
      S_M1: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b0, sh: MAC_SH17};
        mac_a   = pa_r;
        mac_b   = {{2{dy_r[32]}}, dy_r[32:17]};
      end
      S_M2: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b0, sh: MAC_SH0};
        mac_a   = {2'b00, pb_r[33:0]};
        mac_b   = ndx_r;
      end
      S_M3: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b0, sh: MAC_SH34};
        mac_a   = {{20{pb_r[49]}}, pb_r[49:34]};
        mac_b   = ndx_r;
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  lttb_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (acc)
  );

  // Sample store.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && in_data.opcode == OP_LOAD &&
        load_count_r < n_eff) begin
      mem[AW'(load_count_r)] <= in_data.sample_value;
    end
    rd_q <= mem[AW'(raddr)];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      sample_count_r <= '0;
      target_r       <= TARGET_DEFAULT;
      load_count_r   <= '0;
      emit_count_r   <= '0;
      anchor_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.opcode == OP_LOAD) begin
              if (load_count_r < n_eff) begin
                load_count_r <= load_count_r + 1'b1;
              end
            end else if (fetch_ok) begin
              if (!down) begin
                state_r <= S_READ;
              end else if (emit_count_r == '0) begin
                state_r <= S_DIV;
              end else if (is_last) begin
                state_r <= S_READ;
              end else begin
                state_r <= S_BOUND;
              end
            end
          end
        end
        S_DIV:    if (div_cnt_r == 4'd15) state_r <= S_INIT;
        S_INIT:   state_r <= S_READ;
        S_BOUND:  state_r <= S_SUM_RD;
        S_SUM_RD: state_r <= S_SUM_AC;
        S_SUM_AC: state_r <= (j_r + 1'b1 == ne_r) ? S_ANC_RD : S_SUM_RD;
        S_ANC_RD: state_r <= S_ANC_W;
        S_ANC_W:  state_r <= S_PA0;
        S_PA0:    state_r <= S_PA1;
        S_PA1:    state_r <= S_PA2;
        S_PA2:    state_r <= S_PB1;
        S_PB1:    state_r <= S_PB2;
        S_PB2:    state_r <= S_AR_RD;
        S_AR_RD:  state_r <= S_AR_D;
        S_AR_D:   state_r <= S_M0;
        S_M0:     state_r <= S_M1;
        S_M1:     state_r <= S_M2;
        S_M2:     state_r <= S_M3;
        S_M3:     state_r <= S_M4;
        S_M4:     state_r <= S_M5;
        S_M5:     state_r <= (j_r + 1'b1 == end_r) ? S_READ : S_AR_RD;
        S_READ:   state_r <= S_EMIT;
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (last_r) begin
              load_count_r <= '0;
              emit_count_r <= '0;
              anchor_r     <= '0;
            end else begin
              emit_count_r <= emit_count_r + 1'b1;
              anchor_r     <= idx_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT: begin
            sample_count_r <= cfg_wdata;
            load_count_r   <= '0;
            emit_count_r   <= '0;
            anchor_r       <= '0;
          end
          CFG_TARGET_POINTS: begin
            target_r     <= cfg_wdata[15:0];
            emit_count_r <= '0;
            anchor_r     <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        last_r    <= is_last;
        mid_r     <= down && (emit_count_r != '0) && !is_last;
        // The quotient and remainder are kept for the whole path, so the
        // divider is only primed when the first point of a downsampled path is fetched.
        if (in_valid && in_data.opcode == OP_FETCH && fetch_ok && down &&
            emit_count_r == '0) begin
          div_rem_r <= '0;
          div_quo_r <= dvd;
          div_cnt_r <= '0;
        end
        if (!down) begin
          idx_r <= emit_count_r;
        end else if (is_last) begin
          idx_r <= IDX_W'(n_eff - 1'b1);
        end else begin
          idx_r <= '0;
        end
      end
      S_DIV: begin
        div_rem_r <= div_ge ? rem_sh - {1'b0, dvsr} : rem_sh;
        div_quo_r <= {div_quo_r[14:0], div_ge};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      S_INIT: begin
        q0_r <= '0;
        q1_r <= {2'b00, div_quo_r};
        q2_r <= {1'b0, div_quo_r, 1'b0} + 18'(adv_ge_init);
        r2_r <= adv_ge_init ? 16'(adv_s_init - {1'b0, dvsr}) : adv_s_init[15:0];
      end
      S_BOUND: begin
        start_r <= start18[CNT_W-1:0];
        end_r   <= endf[CNT_W-1:0];
        ne_r    <= nef[CNT_W-1:0];
        j_r     <= endc[CNT_W-1:0];
        c_r     <= CNT_W'(nef - endc);
        sx_r    <= '0;
        sy_r    <= '0;
      end
      S_SUM_AC: begin
        sx_r <= sx_r + 33'(j_r);
        sy_r <= sy_r + 50'(rd_q);
        j_r  <= j_r + 1'b1;
      end
      S_ANC_W: ay_r <= rd_q;
      S_PA2:   pa_r <= acc[35:0] - 36'(sx_r);
      S_PB2: begin
        pb_r   <= sy_r - acc[49:0];
        j_r    <= start_r;
        have_r <= 1'b0;
      end
      S_AR_D: begin
        dy_r  <= 33'(rd_q) - 33'(ay_r);
        ndx_r <= {1'b0, j_r} - {2'b00, anchor_r};
      end
      S_M5: begin
        have_r <= 1'b1;
        if (take) begin
          best_r   <= area;
          best_j_r <= j_r;
        end
        j_r   <= j_r + 1'b1;
        idx_r <= take ? IDX_W'(j_r) : IDX_W'(best_j_r);
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_data_r.point_index <= idx_r;
          out_data_r.point_value <= rd_q;
          out_data_r.last_point  <= last_r;
          if (mid_r) begin
            q0_r <= q1_r;
            q1_r <= q2_r;
            q2_r <= q2_r + {2'b00, div_quo_r} + 18'(adv_ge);
            r2_r <= adv_ge ? 16'(adv_s - {1'b0, dvsr}) : adv_s[15:0];
          end
        end
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_count_r <= n_eff)
    else $error("load count ran past the path length");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_count_r == '0) || ({1'b0, emit_count_r} < m_eff))
    else $error("emit count ran past the point count");

  a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_M0) |-> (j_r >= start_r) && (j_r < end_r))
    else $error("area candidate outside the current bucket");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> (div_rem_r < {1'b0, dvsr}))
    else $error("division remainder not below divisor");

  a_fetch_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_data.opcode == OP_FETCH && fetch_ok)
      |=> (state_r != S_IDLE) && loaded)
    else $error("fetch started without a fully loaded path");
`endif

endmodule
